// ----- hw/rtl/pool_free_list_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Pool free-list allocator assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef POOL_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define POOL_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// expr holds at every edge
`define PLFA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons holds in the same cycle as ante
`define PLFA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons holds in the cycle after ante
`define PLFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PLFA_ASSERT_ALWAYS(label, expr, msg)
`define PLFA_ASSERT_IMPL(label, ante, cons, msg)
`define PLFA_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/plfa_pkg.sv -----
// ----------------------------------------------------------------------------
// plfa_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package plfa_pkg;

  localparam int ADDR_W      = 14;
  localparam int CHUNK_W     = 13;
  localparam int RSV_W       = 3;
  localparam int CFG_W       = CHUNK_W;
  localparam int CFG_IDX_W   = 1;
  localparam int STATUS_W    = 2;
  localparam int STACK_DEPTH = 1024;
  localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
  localparam int SP_W        = STACK_IDX_W + 1;

  localparam int BLOCK_BYTES_DEF     = 4096;
  localparam int MAX_BLOCKS_DEF      = 4;
  localparam int MIN_CHUNK_BYTES_DEF = 16;

  localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(16);

  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BYTES     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_BLOCKS = 1'b1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic load_in;
    logic start;
    logic rsv_dec;
    logic block_start;
    logic carve_step;
    logic block_done;
    logic do_free;
    logic do_pop;
    logic set_fail;
    logic out_load;
  } plfa_cmd_t;

  typedef struct packed {
    logic started;
    logic op;
    logic rsv_zero;
    logic all_carved;
    logic stack_empty;
    logic carve_more;
    logic out_free;
  } plfa_stat_t;

endpackage

// ----- hw/rtl/plfa_dp.sv -----
// ----------------------------------------------------------------------------
// plfa_dp
// Datapath: free-address stack memory, carve counters, configuration and
// result registers.
// ----------------------------------------------------------------------------
`include "pool_free_list_allocator_assert.svh"

module plfa_dp #(
  parameter int BLOCK_BYTES     = plfa_pkg::BLOCK_BYTES_DEF,
  parameter int MAX_BLOCKS      = plfa_pkg::MAX_BLOCKS_DEF,
  parameter int MIN_CHUNK_BYTES = plfa_pkg::MIN_CHUNK_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [plfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plfa_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          operation,
  input  logic [plfa_pkg::ADDR_W-1:0]   free_address,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [plfa_pkg::ADDR_W-1:0]   chunk_address,
  output logic [plfa_pkg::STATUS_W-1:0] status,
  input  plfa_pkg::plfa_cmd_t           cmd,
  output plfa_pkg::plfa_stat_t          st
);
  import plfa_pkg::*;

  localparam int OFF_W = $clog2(BLOCK_BYTES + 1);
  localparam int BC_W  = $clog2(MAX_BLOCKS + 1);
  localparam logic [SP_W-1:0]  STACK_FULL = SP_W'(STACK_DEPTH);
  localparam logic [BC_W-1:0]  BLOCKS_ALL = BC_W'(MAX_BLOCKS);
  localparam logic [OFF_W:0]   BLOCK_END  = (OFF_W + 1)'(BLOCK_BYTES);
  localparam logic [ADDR_W-1:0] BLOCK_STEP = ADDR_W'(BLOCK_BYTES);

  logic [CHUNK_W-1:0]  chunk_bytes;
  logic [RSV_W-1:0]    reserved_blocks;
  logic                started;
  logic [RSV_W-1:0]    rsv_left;
  logic [SP_W-1:0]     stack_count;
  logic [BC_W-1:0]     blocks_carved;
  logic [ADDR_W-1:0]   block_base;
  logic [ADDR_W-1:0]   carve_addr;
  logic [OFF_W-1:0]    carve_off;
  logic                op_r;
  logic [ADDR_W-1:0]   faddr_r;
  logic [STATUS_W-1:0] res_status;
  logic                res_from_mem;
  logic [ADDR_W-1:0]   rdata;
  logic [ADDR_W-1:0]   stack_mem [STACK_DEPTH];

  logic [31:0]         chunk_lo;
  logic [31:0]         chunk_sat;
  logic [OFF_W-1:0]    chunk_use;
  logic                stack_full;
  logic                push_we;
  logic [ADDR_W-1:0]   push_data;
  logic [SP_W-1:0]     count_m1;

  // saturate the chunk size to [MIN_CHUNK_BYTES, BLOCK_BYTES]
  always_comb begin
    chunk_lo  = (32'(chunk_bytes) < 32'(MIN_CHUNK_BYTES)) ? 32'(MIN_CHUNK_BYTES)
                                                           : 32'(chunk_bytes);
    chunk_sat = (chunk_lo > 32'(BLOCK_BYTES)) ? 32'(BLOCK_BYTES) : chunk_lo;
    if (chunk_sat == 32'd0) begin
      chunk_sat = 32'd1;
    end
    chunk_use = chunk_sat[OFF_W-1:0];
  end

  assign stack_full = (stack_count == STACK_FULL);
  assign push_we    = (cmd.carve_step || cmd.do_free) && !stack_full;
  assign push_data  = cmd.do_free ? faddr_r : carve_addr;
  assign count_m1   = stack_count - 1'b1;

  assign st.started     = started;
  assign st.op          = op_r;
  assign st.rsv_zero    = (rsv_left == '0);
  assign st.all_carved  = (blocks_carved == BLOCKS_ALL);
  assign st.stack_empty = (stack_count == '0);
  assign st.carve_more  = ({1'b0, carve_off} + {1'b0, chunk_use}) <= BLOCK_END;
  assign st.out_free    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (push_we) begin
      stack_mem[stack_count[STACK_IDX_W-1:0]] <= push_data;
    end
    if (cmd.do_pop) begin
      rdata <= stack_mem[count_m1[STACK_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes     <= CHUNK_RESET;
      reserved_blocks <= '0;
      started         <= 1'b0;
      rsv_left        <= '0;
      stack_count     <= '0;
      blocks_carved   <= '0;
      block_base      <= '0;
      out_valid       <= 1'b0;
    end else begin
      // writes after the first word are ignored
      if (cfg_write && !started) begin
        unique case (cfg_index)
          REG_CHUNK_BYTES:     chunk_bytes     <= cfg_data;
          REG_RESERVED_BLOCKS: reserved_blocks <= cfg_data[RSV_W-1:0];
        endcase
      end
      if (cmd.start) begin
        started  <= 1'b1;
        rsv_left <= reserved_blocks;
      end else if (cmd.rsv_dec) begin
        rsv_left <= rsv_left - 1'b1;
      end
      if (push_we) begin
        stack_count <= stack_count + 1'b1;
      end else if (cmd.do_pop) begin
        stack_count <= count_m1;
      end
      if (cmd.block_done) begin
        blocks_carved <= blocks_carved + 1'b1;
        block_base    <= block_base + BLOCK_STEP;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r    <= operation;
      faddr_r <= free_address;
    end
    if (cmd.block_start) begin
      carve_addr <= block_base;
      carve_off  <= '0;
    end else if (cmd.carve_step) begin
      carve_addr <= carve_addr + ADDR_W'(chunk_use);
      carve_off  <= carve_off + chunk_use;
    end
    if (cmd.do_free) begin
      res_status   <= stack_full ? ST_FULL : ST_OK;
      res_from_mem <= 1'b0;
    end else if (cmd.do_pop) begin
      res_status   <= ST_OK;
      res_from_mem <= 1'b1;
    end else if (cmd.set_fail) begin
      res_status   <= ST_OOM;
      res_from_mem <= 1'b0;
    end
    if (cmd.out_load) begin
      chunk_address <= res_from_mem ? rdata : '0;
      status        <= res_status;
    end
  end

  `PLFA_ASSERT_ALWAYS(a_count_range, stack_count <= STACK_FULL, "stack count past depth")
  `PLFA_ASSERT_IMPL(a_pop_nonempty, cmd.do_pop, stack_count != '0, "pop from empty stack")
  `PLFA_ASSERT_IMPL(a_fail_zero_addr, out_valid && status != ST_OK, chunk_address == '0, "failed word carries an address")

endmodule

// ----- hw/rtl/plfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// plfa_ctrl
// Controller: sequences reserve carving, refill carving, push, pop and
// result hand-off.
// ----------------------------------------------------------------------------
`include "pool_free_list_allocator_assert.svh"

module plfa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  plfa_pkg::plfa_stat_t st,
  output plfa_pkg::plfa_cmd_t  cmd
);
  import plfa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_RSV       = 6'b000010,
    S_CARVE_RSV = 6'b000100,
    S_CARVE_OP  = 6'b001000,
    S_OP        = 6'b010000,
    S_OUT       = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = !((state == S_IDLE) || ((state == S_OUT) && st.out_free));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          if (!st.started) begin
            cmd.start  = 1'b1;
            state_next = S_RSV;
          end else begin
            state_next = S_OP;
          end
        end
      end
      S_RSV: begin
        if (st.rsv_zero || st.all_carved) begin
          state_next = S_OP;
        end else begin
          cmd.block_start = 1'b1;
          cmd.rsv_dec     = 1'b1;
          state_next      = S_CARVE_RSV;
        end
      end
      S_CARVE_RSV, S_CARVE_OP: begin
        if (st.carve_more) begin
          cmd.carve_step = 1'b1;
        end else begin
          cmd.block_done = 1'b1;
          state_next     = (state == S_CARVE_RSV) ? S_RSV : S_OP;
        end
      end
      S_OP: begin
        priority if (st.op == OP_FREE) begin
          cmd.do_free = 1'b1;
          state_next  = S_OUT;
        end else if (!st.stack_empty) begin
          cmd.do_pop = 1'b1;
          state_next = S_OUT;
        end else if (!st.all_carved) begin
          // refill from the next unused block, then retry
          cmd.block_start = 1'b1;
          state_next      = S_CARVE_OP;
        end else begin
          cmd.set_fail = 1'b1;
          state_next   = S_OUT;
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (accept) begin
            cmd.load_in = 1'b1;
            state_next  = S_OP;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `PLFA_ASSERT_NEXT(a_accept_dispatch, accept, state == S_OP || state == S_RSV, "accepted word not dispatched")
  `PLFA_ASSERT_IMPL(a_out_load_free, cmd.out_load, st.out_free, "result loaded over pending word")
  `PLFA_ASSERT_IMPL(a_start_once, cmd.start, !st.started, "reserve carved twice")

endmodule

// ----- hw/rtl/pool_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// pool_free_list_allocator
// Fixed-size chunk allocator on a LIFO free-address stack with block carving.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   in      | input     | in_valid / in_stall | operation, free_address
//   out     | output    | out_valid/out_stall | chunk_address, status
//   cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// A free or a pop handles each word with one stack memory access, then the
// result register load, which overlaps the next accept.
// A refill carves floor(BLOCK_BYTES/chunk) chunks, one push per cycle while
// the stack has room. The first word also passes the reserve check, and each
// reserved block it carves is carved the same way.
// Reset clears stack/block counts and reserve, sets chunk to 16; no memory sweep.
// A stalled result holds in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module pool_free_list_allocator #(
  parameter int BLOCK_BYTES     = plfa_pkg::BLOCK_BYTES_DEF,
  parameter int MAX_BLOCKS      = plfa_pkg::MAX_BLOCKS_DEF,
  parameter int MIN_CHUNK_BYTES = plfa_pkg::MIN_CHUNK_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [plfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plfa_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [plfa_pkg::ADDR_W-1:0]   free_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [plfa_pkg::ADDR_W-1:0]   chunk_address,
  output logic [plfa_pkg::STATUS_W-1:0] status
);
  import plfa_pkg::*;

  plfa_cmd_t  cmd;
  plfa_stat_t st;

  plfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  plfa_dp #(
    .BLOCK_BYTES     (BLOCK_BYTES),
    .MAX_BLOCKS      (MAX_BLOCKS),
    .MIN_CHUNK_BYTES (MIN_CHUNK_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .free_address  (free_address),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .chunk_address (chunk_address),
    .status        (status),
    .cmd           (cmd),
    .st            (st)
  );

endmodule
